// ----- hdl/lir_pkg.sv -----
// shared constants, word types and controller/datapath command types
`default_nettype none

package lir_pkg;

    // sample and rate geometry
    localparam int SAMPLE_BITS   = 24;
    localparam int LANES         = 2;
    localparam int MAX_RATIO_DEF = 32;
    localparam int RATE_W        = 19;
    localparam int CHAN_W        = 2;
    localparam int PHASE_W       = 20;
    localparam int T_W           = PHASE_W + 1;
    localparam int CFG_IDX_W     = 2;

    // divider geometry: quotient bits, dividend width, signed quotient width
    localparam int QB      = SAMPLE_BITS + 1;
    localparam int PROD_W  = QB + RATE_W;
    localparam int QS_W    = QB + 1;
    localparam int STEP_W  = $clog2(QB);

    localparam logic [RATE_W-1:0] IN_RATE_RST  = RATE_W'(48000);
    localparam logic [RATE_W-1:0] OUT_RATE_RST = RATE_W'(48000);
    localparam logic [CHAN_W-1:0] CHAN_RST     = CHAN_W'(2);
    localparam logic [CHAN_W-1:0] CHAN_STEREO  = CHAN_W'(2);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_RATE  = 2'd0,
        CFG_OUT_RATE = 2'd1,
        CFG_CHANNELS = 2'd2
    } cfg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [RATE_W-1:0]             rate_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_a;
        logic signed [SAMPLE_BITS-1:0] sample_b;
        logic                          last_frame;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_a;
        logic signed [SAMPLE_BITS-1:0] out_b;
        logic                          run_end;
        logic                          rate_error;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic push_err;
        logic load_diff;
        logic load_prod;
        logic div_step;
        logic load_qs;
        logic emit_interp;
        logic emit_tail;
        logic adjust_t;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rate_bad;
        logic interp_go;
        logic tail_go;
        logic pend_valid;
        logic push_ok;
    } stat_t;

endpackage

`default_nettype wire

// ----- hdl/lir_stream_if.sv -----
// valid/ready stream channel carrying one word
`default_nettype none

interface lir_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lir_div.sv -----
// restoring divider, one quotient bit per cycle while step is high, for one lane
`default_nettype none

module lir_div (
    input  wire logic                            clk,
    input  wire logic                            load,
    input  wire logic                            step,
    input  wire logic [lir_pkg::PROD_W-1:0]      dividend,
    input  wire logic [lir_pkg::RATE_W-1:0]      den,
    output logic      [lir_pkg::QB-1:0]          quo,
    output logic                                 rem_nz
);

    logic [lir_pkg::RATE_W-1:0] rem_reg;
    logic [lir_pkg::QB-1:0]     quo_reg;
    logic [lir_pkg::RATE_W:0]   trial;
    logic [lir_pkg::RATE_W:0]   diff;
    logic                       ge;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[lir_pkg::QB-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
    end

    // upper dividend bits start below the divisor, so QB steps give the quotient
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= dividend[lir_pkg::PROD_W-1:lir_pkg::QB];
            quo_reg <= dividend[lir_pkg::QB-1:0];
        end
        else if (step)
        begin
            rem_reg <= ge ? diff[lir_pkg::RATE_W-1:0] : trial[lir_pkg::RATE_W-1:0];
            quo_reg <= {quo_reg[lir_pkg::QB-2:0], ge};
        end
    end

    assign quo    = quo_reg;
    assign rem_nz = |rem_reg;

endmodule

`default_nettype wire

// ----- hdl/lir_dp.sv -----
// resampler datapath: config, frame state, phase, lerp lanes, output words
`default_nettype none

module lir_dp #(
    parameter int MAX_RATIO = lir_pkg::MAX_RATIO_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lir_pkg::RATE_W-1:0]        cfg_data,
    input  wire lir_pkg::in_word_t                 in_data,
    input  wire lir_pkg::cmd_t                     cmd,
    output lir_pkg::stat_t                         stat,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output lir_pkg::out_word_t                     out_data
);

    localparam int CNT_W = $clog2(MAX_RATIO + 1);
    localparam int RB_W  = lir_pkg::RATE_W + CNT_W;

    // configuration
    lir_pkg::rate_t              in_rate_reg;
    lir_pkg::rate_t              out_rate_reg;
    logic [lir_pkg::CHAN_W-1:0]  chan_reg;
    logic                        stereo;

    // stream state
    lir_pkg::sample_t            prev_reg [lir_pkg::LANES];
    logic [lir_pkg::PHASE_W-1:0] phase_reg;
    logic                        have_prev_reg;

    // per-word working state
    lir_pkg::sample_t            in_s     [lir_pkg::LANES];
    lir_pkg::sample_t            cur_reg  [lir_pkg::LANES];
    logic                        last_reg;
    logic [lir_pkg::T_W-1:0]     t_reg;
    logic [CNT_W-1:0]            cnt_reg;

    // lane arithmetic
    logic signed [lir_pkg::QB-1:0]   diff_w   [lir_pkg::LANES];
    logic [lir_pkg::QB-1:0]          mag_reg  [lir_pkg::LANES];
    logic                            neg_reg  [lir_pkg::LANES];
    logic [lir_pkg::PROD_W-1:0]      prod_w   [lir_pkg::LANES];
    logic [lir_pkg::QB-1:0]          quo_w    [lir_pkg::LANES];
    logic                            rem_nz_w [lir_pkg::LANES];
    logic signed [lir_pkg::QS_W-1:0] qs_reg   [lir_pkg::LANES];
    logic signed [lir_pkg::QS_W-1:0] sum_w    [lir_pkg::LANES];
    lir_pkg::sample_t                new_w    [lir_pkg::LANES];

    // one word held back until it is known whether it ends the run
    lir_pkg::sample_t            pend_reg [lir_pkg::LANES];
    logic                        pend_valid_reg;

    logic                        out_valid_reg;
    lir_pkg::out_word_t          out_data_reg;

    logic                        emit;
    logic                        push_pend;
    logic [lir_pkg::T_W:0]       tail_sum;
    logic [RB_W-1:0]             rate_cap;

    assign stereo = (chan_reg >= lir_pkg::CHAN_STEREO) && (lir_pkg::LANES >= 2);

    assign in_s[0] = in_data.sample_a;
    assign in_s[1] = in_data.sample_b;

    // ratio check on the current registers
    assign rate_cap = RB_W'(in_rate_reg) * RB_W'(MAX_RATIO);
    assign stat.rate_bad = (in_rate_reg == '0) || (out_rate_reg == '0) ||
                           (RB_W'(out_rate_reg) > rate_cap);

    // loop conditions
    assign tail_sum = (lir_pkg::T_W + 1)'(t_reg) + (lir_pkg::T_W + 1)'(in_rate_reg);
    assign stat.interp_go = have_prev_reg &&
                            (t_reg < lir_pkg::T_W'(out_rate_reg)) &&
                            (cnt_reg != CNT_W'(MAX_RATIO));
    assign stat.tail_go   = last_reg &&
                            (tail_sum <= (lir_pkg::T_W + 1)'(out_rate_reg)) &&
                            (cnt_reg != CNT_W'(MAX_RATIO));
    assign stat.pend_valid = pend_valid_reg;
    assign stat.push_ok    = !out_valid_reg || out_ready;

    assign emit      = cmd.emit_interp | cmd.emit_tail;
    assign push_pend = (emit | cmd.commit) & pend_valid_reg;

    // lanes: difference, multiply, serial divide, floor fix, add back
    for (genvar l = 0; l < lir_pkg::LANES; l++)
    begin : g_lane
        assign diff_w[l] = lir_pkg::QB'(cur_reg[l]) - lir_pkg::QB'(prev_reg[l]);
        assign prod_w[l] = lir_pkg::PROD_W'(mag_reg[l]) *
                           lir_pkg::PROD_W'(t_reg[lir_pkg::RATE_W-1:0]);
        assign sum_w[l]  = lir_pkg::QS_W'(prev_reg[l]) + qs_reg[l];

        always_comb
        begin
            if ((l != 0) && !stereo)
                new_w[l] = '0;
            else if (cmd.emit_tail)
                new_w[l] = cur_reg[l];
            else
                new_w[l] = sum_w[l][lir_pkg::SAMPLE_BITS-1:0];
        end

        lir_div u_div (
            .clk      (clk),
            .load     (cmd.load_prod),
            .step     (cmd.div_step),
            .dividend (prod_w[l]),
            .den      (out_rate_reg),
            .quo      (quo_w[l]),
            .rem_nz   (rem_nz_w[l])
        );

        always_ff @(posedge clk)
        begin
            if (cmd.capture)
                cur_reg[l] <= ((l == 0) || stereo) ? in_s[l] : '0;
            if (cmd.load_diff)
            begin
                neg_reg[l] <= diff_w[l][lir_pkg::QB-1];
                mag_reg[l] <= diff_w[l][lir_pkg::QB-1] ? -diff_w[l] : diff_w[l];
            end
            // floor of a negative quotient rounds away from zero on a remainder
            if (cmd.load_qs)
                qs_reg[l] <= neg_reg[l] ?
                    -(lir_pkg::QS_W'(quo_w[l]) + lir_pkg::QS_W'(rem_nz_w[l])) :
                    lir_pkg::QS_W'(quo_w[l]);
            if (emit)
                pend_reg[l] <= new_w[l];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            last_reg <= in_data.last_frame;
        if (cmd.push_err)
        begin
            out_data_reg.out_a      <= '0;
            out_data_reg.out_b      <= '0;
            out_data_reg.run_end    <= 1'b1;
            out_data_reg.rate_error <= 1'b1;
        end
        else if (push_pend)
        begin
            out_data_reg.out_a      <= pend_reg[0];
            out_data_reg.out_b      <= pend_reg[1];
            out_data_reg.run_end    <= cmd.commit;
            out_data_reg.rate_error <= 1'b0;
        end
    end

    // config, stream state, phase and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg    <= lir_pkg::IN_RATE_RST;
            out_rate_reg   <= lir_pkg::OUT_RATE_RST;
            chan_reg       <= lir_pkg::CHAN_RST;
            for (int l = 0; l < lir_pkg::LANES; l++)
                prev_reg[l] <= '0;
            phase_reg      <= '0;
            have_prev_reg  <= 1'b0;
            t_reg          <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lir_pkg::CFG_IN_RATE:  in_rate_reg  <= cfg_data;
                    lir_pkg::CFG_OUT_RATE: out_rate_reg <= cfg_data;
                    lir_pkg::CFG_CHANNELS: chan_reg     <= cfg_data[lir_pkg::CHAN_W-1:0];
                    default: ;
                endcase
            end

            // phase walk
            if (cmd.capture)
            begin
                t_reg   <= have_prev_reg ? lir_pkg::T_W'(phase_reg) : '0;
                cnt_reg <= '0;
            end
            else if (cmd.adjust_t)
            begin
                t_reg   <= (t_reg >= lir_pkg::T_W'(out_rate_reg)) ?
                           t_reg - lir_pkg::T_W'(out_rate_reg) : '0;
                cnt_reg <= '0;
            end
            else if (emit)
            begin
                t_reg   <= t_reg + lir_pkg::T_W'(in_rate_reg);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            // stream state update at the end of a frame
            if (cmd.commit)
            begin
                for (int l = 0; l < lir_pkg::LANES; l++)
                    prev_reg[l] <= last_reg ? '0 : cur_reg[l];
                phase_reg     <= last_reg ? '0 : t_reg[lir_pkg::PHASE_W-1:0];
                have_prev_reg <= !last_reg;
            end

            if (emit)
                pend_valid_reg <= 1'b1;
            else if (cmd.commit)
                pend_valid_reg <= 1'b0;

            out_valid_reg <= push_pend | cmd.push_err | (out_valid_reg & ~out_ready);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hdl/lir_ctrl.sv -----
// resampler controller: sequences lerp, hold and error words for one frame
`default_nettype none

module lir_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lir_pkg::stat_t stat,
    output lir_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_LOOP_I,
        S_MUL,
        S_DIV,
        S_QS,
        S_EMIT_I,
        S_LOOP_T,
        S_DONE
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [lir_pkg::STEP_W-1:0] step_reg;
    logic [lir_pkg::STEP_W-1:0] step_next;
    logic                       slot_free;

    // a new word may enter the pending slot when it is empty or drains now
    assign slot_free = !stat.pend_valid || stat.push_ok;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.rate_bad ? S_ERR : S_LOOP_I;
                end
            end
            S_ERR:
            begin
                if (stat.push_ok)
                begin
                    cmd.push_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LOOP_I:
            begin
                if (stat.interp_go)
                begin
                    cmd.load_diff = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.adjust_t = 1'b1;
                    state_next   = S_LOOP_T;
                end
            end
            S_MUL:
            begin
                cmd.load_prod = 1'b1;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == lir_pkg::STEP_W'(lir_pkg::QB - 1))
                    state_next = S_QS;
                else
                    step_next = step_reg + lir_pkg::STEP_W'(1);
            end
            S_QS:
            begin
                cmd.load_qs = 1'b1;
                state_next  = S_EMIT_I;
            end
            S_EMIT_I:
            begin
                if (slot_free)
                begin
                    cmd.emit_interp = 1'b1;
                    state_next      = S_LOOP_I;
                end
            end
            S_LOOP_T:
            begin
                if (stat.tail_go)
                begin
                    if (slot_free)
                        cmd.emit_tail = 1'b1;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/linear_interp_resampler.sv -----
// linear interpolation resampler top level
//
//   channel   direction  word          contents
//   din       sink       in_word_t     sample_a, sample_b, last_frame
//   dout      source     out_word_t    out_a, out_b, run_end, rate_error
//   cfg_*     write      index + data  in_rate, out_rate, channel_count
//
// one frame is worked at a time; an interpolated word passes the loop check, multiply,
// serial divide and quotient fix states, the divider giving one quotient bit a cycle,
// and a held tail word is emitted straight from the tail loop state
// a bad ratio gives one error word once the output can take it; stream state is untouched
// reset clears config to defaults and the stream state at once, no clearing pass
// output stalls back up through one output register and one pending word
`default_nettype none

module linear_interp_resampler #(
    parameter int MAX_RATIO = lir_pkg::MAX_RATIO_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lir_pkg::RATE_W-1:0]    cfg_data,
    lir_stream_if.sink                         din,
    lir_stream_if.source                       dout
);

    lir_pkg::cmd_t  cmd;
    lir_pkg::stat_t stat;

    // sequencing
    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    lir_dp #(
        .MAX_RATIO (MAX_RATIO)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (din.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .out_data  (dout.data)
    );

endmodule

`default_nettype wire
